### design/cgs_pkg.sv
// Shared widths and constants of the clipped gaussian sampler.
// No dependencies; every other design file imports this package.
package cgs_pkg;

	// Input and result word widths
	localparam int UW_W  = 31;
	localparam int Q_W   = 32;

	// Attempt counter
	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] MAX_ATTEMPTS = 7'd100;

	// Shared multiplier operand and product widths
	localparam int MA_W = 36;
	localparam int MB_W = 32;
	localparam int MP_W = MA_W + MB_W;

	// Compare-subtract width
	localparam int CS_W = 64;

	// Acceptance window of s in Q0.60
	localparam logic [61:0] S_MIN_Q60 = 62'd1152921504606;
	localparam logic [61:0] ONE_Q60   = 62'd1 << 60;

	// ln 2 in Q0.28
	localparam logic [MB_W-1:0] LN2_Q28 = 32'd186065279;

	// Half scale of the uniform words (1.0 in Q1.30)
	localparam logic [UW_W-1:0] HALF_W = 31'd1 << 30;

endpackage

### design/cgs_in_if.sv
// Input channel of the sampler: valid/ready plus the request word.
// Depends on cgs_pkg for field widths.
interface cgs_in_if import cgs_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [UW_W-1:0] u_word;
	logic [UW_W-1:0] v_word;
	logic [Q_W-1:0]  mean_value;
	logic [Q_W-1:0]  deviation;

	modport source(output valid, u_word, v_word, mean_value, deviation, input ready);
	modport sink(input valid, u_word, v_word, mean_value, deviation, output ready);
endinterface

### design/cgs_out_if.sv
// Output channel of the sampler: valid/ready plus the sample word.
// Depends on cgs_pkg for field widths.
interface cgs_out_if import cgs_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [Q_W-1:0] sample_value;
	logic           fell_back;

	modport source(output valid, sample_value, fell_back, input ready);
	modport sink(input valid, sample_value, fell_back, output ready);
endinterface

### design/cgs_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on cgs_pkg for operand widths.
module cgs_mul import cgs_pkg::*; (
	input  logic            clk,
	input  logic [MA_W-1:0] a,
	input  logic [MB_W-1:0] b,
	output logic [MP_W-1:0] prod_q
);

	// Register the product every cycle
	always_ff @(posedge clk) begin
		prod_q <= MP_W'(a) * MP_W'(b);
	end

endmodule

### design/cgs_cmpsub.sv
// Shared compare-and-subtract step for the restoring divide and square root.
// Depends on cgs_pkg for the datapath width.
module cgs_cmpsub import cgs_pkg::*; (
	input  logic [CS_W-1:0] x,
	input  logic [CS_W-1:0] y,
	output logic            ge,
	output logic [CS_W-1:0] diff
);

	// Compare and subtract in one adder
	logic [CS_W:0] d;
	assign d    = {1'b0, x} - {1'b0, y};
	assign ge   = ~d[CS_W];
	assign diff = d[CS_W-1:0];

endmodule

### design/clipped_gaussian_sampler.sv
// Top level of the clipped gaussian sampler: sequencer around one shared
// multiplier and one shared compare-subtract step. Depends on cgs_pkg,
// cgs_in_if, cgs_out_if, cgs_mul and cgs_cmpsub.
//
//   channel | dir | word
//   req     | in  | u_word, v_word, mean_value, deviation
//   res     | out | sample_value, fell_back
//
// One input word at a time: the sequencer forms s, normalizes it, runs the
// log2 squaring steps, applies the ln 2 scale, divides, takes the square root
// and forms the candidates, sharing the multiplier and compare-subtract. A
// rejected pair returns to idle after the s test.
// Reset clears the sequencer, the attempt count and the output valid.
// A waiting result holds the sequencer only when a new result is ready.
module clipped_gaussian_sampler import cgs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	cgs_in_if.sink  req,
	cgs_out_if.source res
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_SQ_U, ST_SQ_V, ST_SQ_SUM, ST_NORM, ST_LOG_MUL, ST_LOG_ACC,
		ST_N_MUL, ST_N_TAKE, ST_DIV, ST_SQRT, ST_Z_MUL, ST_T_MUL, ST_CHECK,
		ST_FINISH
	} state_t;

	state_t           state_q;
	logic [UW_W-1:0]  au_q, av_q;
	logic             uneg_q, vneg_q;
	logic [Q_W-1:0]   mean_q, dev_q;
	logic [60:0]      acc_q;
	logic [59:0]      s_q;
	logic [60:0]      m_q;
	logic [5:0]       k_q;
	logic [30:0]      x_q;
	logic [29:0]      fr_q;
	logic [5:0]       step_q;
	logic [59:0]      rem_q;
	logic [53:0]      quo_q;
	logic [CS_W-1:0]  a_q, root_q;
	logic [62:0]      bit_q;
	logic [Q_W-1:0]   f_q;
	logic             sel_q;
	logic [CNT_W-1:0] cnt_q;
	logic [Q_W-1:0]   rslt_val_q;
	logic             rslt_fb_q;
	logic             out_valid_q;
	logic [Q_W-1:0]   out_val_q;
	logic             out_fb_q;

	// Map the uniform words to sign and magnitude
	logic            in_uneg, in_vneg;
	logic [UW_W-1:0] in_au, in_av;
	assign in_uneg = ~req.u_word[UW_W-1];
	assign in_vneg = ~req.v_word[UW_W-1];
	assign in_au   = in_uneg ? HALF_W - req.u_word : req.u_word - HALF_W;
	assign in_av   = in_vneg ? HALF_W - req.v_word : req.v_word - HALF_W;

	// Shared multiplier
	logic [MA_W-1:0] mul_a;
	logic [MB_W-1:0] mul_b;
	logic [MP_W-1:0] prod_q;

	cgs_mul u_mul (
		.clk   (clk),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	// Derived operands
	logic [35:0] l2;
	logic [28:0] z_val;
	logic [44:0] t_val;
	assign l2    = {k_q, 30'd0} - {6'd0, fr_q};
	assign z_val = prod_q[61:33];
	assign t_val = prod_q[60:16];

	// Select multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQ_U: begin
				mul_a = MA_W'(au_q);
				mul_b = MB_W'(au_q);
			end
			ST_SQ_V: begin
				mul_a = MA_W'(av_q);
				mul_b = MB_W'(av_q);
			end
			ST_LOG_MUL: begin
				mul_a = MA_W'(x_q);
				mul_b = MB_W'(x_q);
			end
			ST_N_MUL: begin
				mul_a = l2;
				mul_b = LN2_Q28;
			end
			ST_Z_MUL: begin
				mul_a = MA_W'(sel_q ? av_q : au_q);
				mul_b = f_q;
			end
			ST_T_MUL: begin
				mul_a = MA_W'(z_val);
				mul_b = dev_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Shared compare-subtract
	logic [CS_W-1:0] cs_x, cs_y, cs_diff;
	logic            cs_ge;

	always_comb begin
		if (state_q == ST_SQRT) begin
			cs_x = a_q;
			cs_y = root_q + CS_W'(bit_q);
		end else begin
			cs_x = CS_W'({rem_q, 1'b0});
			cs_y = CS_W'(s_q);
		end
	end

	cgs_cmpsub u_cmpsub (
		.x   (cs_x),
		.y   (cs_y),
		.ge  (cs_ge),
		.diff(cs_diff)
	);

	// Combinational helpers for the s test, log step and candidate check
	logic [61:0]      s_sum;
	logic [31:0]      y_sq;
	logic [45:0]      pos_sum;
	logic             cand_neg, cand_ok;
	logic [Q_W-1:0]   cand_val;
	logic [CNT_W-1:0] cnt_inc;

	assign s_sum   = 62'(acc_q) + 62'(prod_q[60:0]);
	assign y_sq    = prod_q[61:30];
	assign pos_sum = 46'(mean_q) + 46'(t_val);
	assign cnt_inc = cnt_q + 1'b1;
	assign cand_neg = sel_q ? vneg_q : uneg_q;

	always_comb begin
		if (cand_neg) begin
			cand_ok  = 45'(t_val) < 45'(mean_q);
			cand_val = mean_q - t_val[Q_W-1:0];
		end else begin
			cand_ok  = pos_sum != '0;
			cand_val = (pos_sum[45:Q_W] != '0) ? '1 : pos_sum[Q_W-1:0];
		end
	end

	assign req.ready        = (state_q == ST_IDLE);
	assign res.valid        = out_valid_q;
	assign res.sample_value = out_val_q;
	assign res.fell_back    = out_fb_q;

	// Sequencer: state, control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a finished word, or drop the output word once taken
			if (state_q == ST_FINISH && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						au_q    <= in_au;
						av_q    <= in_av;
						uneg_q  <= in_uneg;
						vneg_q  <= in_vneg;
						mean_q  <= req.mean_value;
						dev_q   <= req.deviation;
						state_q <= ST_SQ_U;
					end
				end
				ST_SQ_U: state_q <= ST_SQ_V;
				ST_SQ_V: begin
					acc_q   <= prod_q[60:0];
					state_q <= ST_SQ_SUM;
				end
				ST_SQ_SUM: begin
					// Drop pairs outside the open interval
					if (s_sum <= S_MIN_Q60 || s_sum >= ONE_Q60) begin
						state_q <= ST_IDLE;
					end else begin
						s_q     <= s_sum[59:0];
						m_q     <= s_sum[60:0];
						k_q     <= '0;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (!m_q[60] && k_q < 6'd60) begin
						m_q <= {m_q[59:0], 1'b0};
						k_q <= k_q + 1'b1;
					end else begin
						x_q     <= m_q[60:30];
						fr_q    <= '0;
						step_q  <= '0;
						state_q <= ST_LOG_MUL;
					end
				end
				ST_LOG_MUL: state_q <= ST_LOG_ACC;
				ST_LOG_ACC: begin
					fr_q <= {fr_q[28:0], y_sq[31]};
					x_q  <= y_sq[31] ? y_sq[31:1] : y_sq[30:0];
					if (step_q == 6'd29) begin
						state_q <= ST_N_MUL;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_LOG_MUL;
					end
				end
				ST_N_MUL: state_q <= ST_N_TAKE;
				ST_N_TAKE: begin
					rem_q   <= 60'(prod_q[MP_W-1:27]);
					quo_q   <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// Advance one quotient bit
					rem_q <= cs_ge ? cs_diff[59:0] : cs_x[59:0];
					quo_q <= {quo_q[52:0], cs_ge};
					if (step_q == 6'd59) begin
						a_q     <= CS_W'({quo_q, cs_ge, 8'd0});
						root_q  <= '0;
						bit_q   <= 63'd1 << 62;
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SQRT: begin
					// Advance one root bit
					if (cs_ge) begin
						a_q    <= cs_diff;
						root_q <= (root_q >> 1) + CS_W'(bit_q);
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						f_q     <= cs_ge ? Q_W'((root_q >> 1) + 64'd1) : Q_W'(root_q >> 1);
						sel_q   <= 1'b0;
						state_q <= ST_Z_MUL;
					end
				end
				ST_Z_MUL: state_q <= ST_T_MUL;
				ST_T_MUL: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (cand_ok) begin
						rslt_val_q <= cand_val;
						rslt_fb_q  <= 1'b0;
						cnt_q      <= '0;
						state_q    <= ST_FINISH;
					end else if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= ST_Z_MUL;
					end else if (cnt_inc >= MAX_ATTEMPTS) begin
						rslt_val_q <= mean_q;
						rslt_fb_q  <= 1'b1;
						cnt_q      <= '0;
						state_q    <= ST_FINISH;
					end else begin
						cnt_q   <= cnt_inc;
						state_q <= ST_IDLE;
					end
				end
				ST_FINISH: begin
					// Hold until the output register is free
					if (!out_valid_q || res.ready) begin
						out_val_q   <= rslt_val_q;
						out_fb_q    <= rslt_fb_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### tb/sv/clipped_gaussian_sampler_tb.sv
// Self-checking bench for clipped_gaussian_sampler: directed and random request words with
// idling on both channels, checked against a bit-exact fixed-point sampler model.
// Depends on cgs_pkg, cgs_in_if, cgs_out_if and the sampler RTL.
module clipped_gaussian_sampler_tb;
	import cgs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [Q_W-1:0] sample_value;
		logic           fell_back;
	} sample_t;

	// Sample predictor and store of pending samples
	class sample_scoreboard;
		logic [CNT_W-1:0] attempts;
		sample_t          pending[$];
		int               errors;
		int               produced;

		function new();
			attempts = '0;
			errors = 0;
			produced = 0;
		endfunction

		// -2 ln(s) in Q.30 from s in Q0.60
		function automatic bit [63:0] neg_two_ln(input bit [63:0] s);
			bit [63:0] m, x, fr, l2, k;
			m = s;
			k = 0;
			fr = 0;
			while (k < 60 && m[60] == 1'b0) begin
				m = m << 1;
				k = k + 1;
			end
			x = m >> 30;
			for (int i = 0; i < 30; i++) begin
				x = (x * x) >> 30;
				fr = fr << 1;
				if (x >= (64'd1 << 31)) begin
					fr[0] = 1'b1;
					x = x >> 1;
				end
			end
			l2 = (k << 30) - fr;
			return (l2 * 64'(LN2_Q28)) >> 27;
		endfunction

		// n * 2^60 / s, truncated to 64 bits
		function automatic bit [63:0] ratio_q30(input bit [63:0] n, input bit [63:0] s);
			bit [63:0] quo, rem;
			quo = n / s;
			rem = n % s;
			for (int i = 0; i < 60; i++) begin
				rem = rem << 1;
				quo = quo << 1;
				if (rem >= s) begin
					rem = rem - s;
					quo[0] = 1'b1;
				end
			end
			return quo;
		endfunction

		function automatic bit [63:0] int_root(input bit [63:0] a);
			bit [63:0] r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > a)
				b = b >> 2;
			while (b != 0) begin
				if (a >= r + b) begin
					a = a - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		// Candidate mean +/- dev*|w|*f; true when above zero
		function automatic bit positive_draw(input bit [63:0] mag, input bit neg,
				input bit [63:0] f, input bit [63:0] mean, input bit [63:0] dev,
				output bit [63:0] val);
			bit [63:0] z, t;
			z = (mag * f) >> 33;
			t = (dev * z) >> 16;
			val = 0;
			if (neg) begin
				if (t >= mean)
					return 0;
				val = mean - t;
				return 1;
			end
			val = mean + t;
			if (val == 0)
				return 0;
			if (val > 64'hFFFF_FFFF)
				val = 64'hFFFF_FFFF;
			return 1;
		endfunction

		// Note an accepted request word and queue its sample, if any
		function void note(input logic [UW_W-1:0] uw, input logic [UW_W-1:0] vw,
				input logic [Q_W-1:0] mean, input logic [Q_W-1:0] dev);
			bit        uneg, vneg, hit;
			bit [63:0] au, av, s, f, val;
			sample_t   e;
			uneg = uw < HALF_W;
			vneg = vw < HALF_W;
			au = uneg ? 64'(HALF_W) - 64'(uw) : 64'(uw) - 64'(HALF_W);
			av = vneg ? 64'(HALF_W) - 64'(vw) : 64'(vw) - 64'(HALF_W);
			s = au * au + av * av;
			if (s <= 64'(S_MIN_Q60) || s >= 64'(ONE_Q60))
				return;
			f = int_root(ratio_q30(neg_two_ln(s), s) << 8);
			attempts = attempts + 1'b1;
			hit = positive_draw(au, uneg, f, 64'(mean), 64'(dev), val);
			if (!hit)
				hit = positive_draw(av, vneg, f, 64'(mean), 64'(dev), val);
			if (hit) begin
				attempts = '0;
				e.sample_value = val[31:0];
				e.fell_back = 1'b0;
			end else if (attempts >= MAX_ATTEMPTS) begin
				attempts = '0;
				e.sample_value = mean;
				e.fell_back = 1'b1;
			end else begin
				return;
			end
			pending.push_back(e);
			produced++;
		endfunction

		// Compare a delivered sample with the oldest pending one
		function void check(input logic [Q_W-1:0] sv, input logic fb);
			sample_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected sample %h fell_back %b", sv, fb);
				return;
			end
			e = pending.pop_front();
			if (sv !== e.sample_value || fb !== e.fell_back) begin
				errors++;
				if (errors <= 10)
					$display("sample mismatch: expected %h/%b, got %h/%b",
						e.sample_value, e.fell_back, sv, fb);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	cgs_in_if  req();
	cgs_out_if res();

	clipped_gaussian_sampler uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.res(res.source)
	);

	sample_scoreboard sb = new();
	bit steady;      // no idling on either side
	bit hold_rx;     // ask the receiver for one long hold-off
	int sent;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("tb: failure");
		$finish;
	end

	// Watch both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note(req.u_word, req.v_word, req.mean_value, req.deviation);
			if (res.valid && res.ready)
				sb.check(res.sample_value, res.fell_back);
		end
	end

	// Drive ready: random stalls, one long hold-off
	initial begin
		int hold;
		hold = 0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				hold_rx = 1'b0;
				hold = 3000;
			end
			if (hold > 0) begin
				hold--;
				res.ready = 1'b0;
			end else begin
				res.ready = steady || ($urandom_range(99) >= 30);
			end
		end
	end

	// Offer one word and hold it until accepted; called at a falling edge
	task automatic offer(input logic [UW_W-1:0] uw, input logic [UW_W-1:0] vw,
			input logic [Q_W-1:0] mean, input logic [Q_W-1:0] dev);
		while (!steady && $urandom_range(99) < 30) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid = 1'b1;
		req.u_word = uw;
		req.v_word = vw;
		req.mean_value = mean;
		req.deviation = dev;
		do
			@(posedge clk);
		while (!req.ready);
		@(negedge clk);
		req.valid = 1'b0;
		sent++;
	endtask

	// Word whose pair lies safely inside the unit circle
	function automatic logic [UW_W-1:0] inner_word();
		logic [UW_W-1:0] m;
		m = UW_W'($urandom_range(1 << 29, 1 << 21));
		return $urandom_range(1) ? HALF_W + m : HALF_W - m;
	endfunction

	function automatic logic [UW_W-1:0] any_word();
		case ($urandom_range(9))
			0: return HALF_W + UW_W'($urandom_range(1 << 21)) - UW_W'(1 << 20);
			1: return $urandom_range(1) ? '1 : '0;
			2, 3: return inner_word();
			default: return UW_W'($urandom());
		endcase
	endfunction

	// Issue one request: repeat mean and deviation until it yields a sample
	task automatic request(input logic [Q_W-1:0] mean, input logic [Q_W-1:0] dev);
		int done_at;
		done_at = sb.produced;
		while (sb.produced == done_at) begin
			offer(any_word(), any_word(), mean, dev);
			if (sent == 300)
				hold_rx = 1'b1;
			steady = (sent >= 500 && sent < 700);
		end
	endtask

	initial begin
		logic [Q_W-1:0] mean, dev;
		int wait_cnt;
		sent = 0;
		steady = 1'b0;
		hold_rx = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.u_word = '0;
		req.v_word = '0;
		req.mean_value = '0;
		req.deviation = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Rejected pairs: corners, exact center, just above center
		offer('0, '0, 32'd5, 32'd5);
		offer('1, '1, 32'd5, 32'd5);
		offer(HALF_W, HALF_W, 32'd5, 32'd5);
		offer(UW_W'(HALF_W + 1), HALF_W, 32'd5, 32'd5);
		offer(UW_W'(HALF_W + (1 << 20)), HALF_W, 32'd5, 32'd5);
		// Accepted near both ends of the window
		offer(UW_W'(HALF_W + (1 << 20) + (1 << 18)), HALF_W, 32'h0001_0000, 32'h0001_0000);
		offer('1, HALF_W, 32'h0001_0000, 32'h0001_0000);
		offer(UW_W'(1), HALF_W, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// Saturation with positive u
		offer(UW_W'(HALF_W + (1 << 25)), UW_W'(HALF_W + (1 << 25)), 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		// Negative u fails, v tried next
		offer(UW_W'(HALF_W - (1 << 28)), UW_W'(HALF_W + (1 << 27)), 32'd1, 32'hFFFF_FFFF);
		offer(UW_W'(HALF_W - (1 << 28)), UW_W'(HALF_W - (1 << 27)), 32'd1, 32'hFFFF_FFFF);
		// Sender pause until everything has drained
		wait (sb.pending.size() == 0);
		@(negedge clk);

		// Fallback: every attempt fails with zero mean and deviation
		for (int i = int'(sb.attempts); i < int'(MAX_ATTEMPTS); i++)
			offer(inner_word(), inner_word(), '0, '0);
		// Success on the last attempt is kept
		for (int i = 0; i < MAX_ATTEMPTS - 1; i++)
			offer(inner_word(), inner_word(), '0, '0);
		offer(inner_word(), inner_word(), 32'd1, '0);

		// Random requests
		while (sent < 1200) begin
			case ($urandom_range(19))
				0: begin
					mean = '0;
					dev = '0;
				end
				1, 2, 3: begin
					mean = $urandom_range(3);
					dev = $urandom();
				end
				4: begin
					mean = '1;
					dev = '1;
				end
				default: begin
					mean = $urandom();
					dev = $urandom() >> $urandom_range(31);
				end
			endcase
			request(mean, dev);
		end
		req.valid = 1'b0;
		steady = 1'b0;

		// Drain, then allow the block to settle
		wait_cnt = 0;
		while (sb.pending.size() != 0 && wait_cnt < 200000) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (400) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

### filelist.f
design/cgs_pkg.sv
design/cgs_in_if.sv
design/cgs_out_if.sv
design/cgs_mul.sv
design/cgs_cmpsub.sv
design/clipped_gaussian_sampler.sv
tb/sv/clipped_gaussian_sampler_tb.sv
